// ===== rtl/core/cdrr_pkg.sv =====
// ----------------------------------------------------------------------------
// cdrr_pkg
// Constants and the answer record table shared by the captive DNS reply
// rewriter.
// ----------------------------------------------------------------------------
package cdrr_pkg;

   localparam int unsigned POS_W          = 10;
   localparam int unsigned MAX_PACKET_DEF = 512;
   localparam int unsigned TAIL_IDX_W     = 4;
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned CSR_DATA_W     = 32;

   localparam logic [POS_W-1:0] HEADER_LEN  = POS_W'(12);
   localparam logic [POS_W-1:0] LABEL_START = POS_W'(12);
   localparam logic [POS_W-1:0] QEND_OFFSET = POS_W'(5);
   localparam logic [POS_W:0]   ANSWER_LEN  = (POS_W+1)'(16);
   localparam logic [POS_W:0]   LABEL_LIMIT = (POS_W+1)'(1023);

   localparam logic [POS_W-1:0] POS_FLAGS_HI = POS_W'(2);
   localparam logic [POS_W-1:0] POS_FLAGS_LO = POS_W'(3);
   localparam logic [POS_W-1:0] POS_ANCOUNT_HI = POS_W'(6);
   localparam logic [POS_W-1:0] POS_ANCOUNT_LO = POS_W'(7);
   localparam logic [POS_W-1:0] POS_NSCOUNT_HI = POS_W'(8);
   localparam logic [POS_W-1:0] POS_ARCOUNT_LO = POS_W'(11);

   localparam logic [7:0] FLAGS_HI_BYTE = 8'h81;
   localparam logic [7:0] FLAGS_LO_BYTE = 8'h80;
   localparam logic [7:0] ANCOUNT_BYTE  = 8'h01;

   localparam logic [TAIL_IDX_W-1:0] TAIL_LAST = TAIL_IDX_W'(15);

   localparam logic [CSR_DATA_W-1:0] ANSWER_ADDRESS_RESET = 32'hC0A8_0401;
   localparam logic                  REG_ANSWER_ADDRESS   = 1'b0;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       end_of_reply;
      logic       reply_status;
   } rsp_word_type;

   function automatic logic [7:0] tail_byte(input logic [TAIL_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] addr);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'hC0;
         4'd1:    b = 8'h0C;
         4'd2:    b = 8'h00;
         4'd3:    b = 8'h01;
         4'd4:    b = 8'h00;
         4'd5:    b = 8'h01;
         4'd6:    b = 8'h00;
         4'd7:    b = 8'h00;
         4'd8:    b = 8'h00;
         4'd9:    b = 8'h3C;
         4'd10:   b = 8'h00;
         4'd11:   b = 8'h04;
         4'd12:   b = addr[31:24];
         4'd13:   b = addr[23:16];
         4'd14:   b = addr[15:8];
         default: b = addr[7:0];
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/captive_dns_reply_rewriter_top.sv =====
// ----------------------------------------------------------------------------
// captive_dns_reply_rewriter_top
// Streams a DNS query in and the captive portal reply out, one word a cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one query byte per cycle and gives one reply word per cycle unless
// stalled; each byte passes the input register, then the result register. The
// final byte of a well-formed query is followed by the 16-word A record; the
// input is held while the record generator runs. A query that cannot be
// answered ends in one word with end_of_reply and reply_status set. Bytes past
// MAX_PACKET produce no word. answer_address sits at byte address 0.
module captive_dns_reply_rewriter_top #(
   parameter int unsigned MAX_PACKET = cdrr_pkg::MAX_PACKET_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_packet_byte,
   input  logic                                 req_end_of_packet,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_reply_byte,
   output logic                                 rsp_end_of_reply,
   output logic                                 rsp_reply_status,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cdrr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cdrr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cdrr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import cdrr_pkg::*;

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET);
   localparam logic [POS_W:0]   MAX_EXT = (POS_W+1)'(MAX_PACKET);

   logic [CSR_DATA_W-1:0] answer_address_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eop_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] nlabel_ff, nlabel_in;
   logic             found_ff, found_in;
   logic [POS_W-1:0] qend_ff, qend_in;

   logic                  tail_active_ff, tail_active_in;
   logic [TAIL_IDX_W-1:0] tail_idx_ff, tail_idx_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic             out_free, proc_go, in_take, csr_write;
   logic             pos_ok, kept, have_byte, label_hit, pkt_ok;
   logic [7:0]       ob;
   logic [POS_W:0]   nx_sum;
   logic [POS_W-1:0] len;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ANSWER_ADDRESS) ? answer_address_ff
                                                            : '0;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_go   = in_valid_ff && !tail_active_ff && out_free;
   assign in_take   = !in_valid_ff || proc_go;
   assign req_stall = !in_take;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_byte   = rsp_word_ff.reply_byte;
   assign rsp_end_of_reply = rsp_word_ff.end_of_reply;
   assign rsp_reply_status = rsp_word_ff.reply_status;

   assign pos_ok    = pos_ff < MAX_POS;
   assign kept      = !(found_ff && (pos_ff >= qend_ff));
   assign have_byte = pos_ok && kept;
   assign label_hit = pos_ok && !found_ff && (pos_ff == nlabel_ff);
   assign nx_sum    = {1'b0, pos_ff} + {{(POS_W-7){1'b0}}, in_byte_ff} + (POS_W+1)'(1);

   always_comb begin
      ob = in_byte_ff;
      case (pos_ff) inside
         POS_FLAGS_HI:                              ob = FLAGS_HI_BYTE;
         POS_FLAGS_LO:                              ob = FLAGS_LO_BYTE;
         POS_ANCOUNT_LO:                            ob = ANCOUNT_BYTE;
         POS_ANCOUNT_HI, [POS_NSCOUNT_HI:POS_ARCOUNT_LO]: ob = 8'h00;
         default:                                   ob = in_byte_ff;
      endcase
   end

   always_comb begin
      pos_in    = pos_ok ? pos_ff + POS_W'(1) : pos_ff;
      nlabel_in = nlabel_ff;
      found_in  = found_ff;
      qend_in   = qend_ff;
      if (label_hit) begin
         if (in_byte_ff == 8'h00) begin
            found_in = 1'b1;
            qend_in  = pos_ff + QEND_OFFSET;
         end else begin
            nlabel_in = (nx_sum > LABEL_LIMIT) ? LABEL_LIMIT[POS_W-1:0]
                                               : nx_sum[POS_W-1:0];
         end
      end
      len    = pos_in;
      pkt_ok = (len >= HEADER_LEN) && found_in && (qend_in <= len) &&
               (({1'b0, qend_in} + ANSWER_LEN) <= MAX_EXT);
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_word_in    = rsp_word_ff;
      tail_active_in = tail_active_ff;
      tail_idx_in    = tail_idx_ff;
      if (tail_active_ff && out_free) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.reply_byte   = tail_byte(tail_idx_ff, answer_address_ff);
         rsp_word_in.end_of_reply = (tail_idx_ff == TAIL_LAST);
         rsp_word_in.reply_status = 1'b0;
         tail_idx_in              = tail_idx_ff + TAIL_IDX_W'(1);
         if (tail_idx_ff == TAIL_LAST) begin
            tail_active_in = 1'b0;
         end
      end else if (proc_go) begin
         rsp_word_in.reply_status = 1'b0;
         rsp_word_in.end_of_reply = 1'b0;
         rsp_word_in.reply_byte   = ob;
         if (!in_eop_ff) begin
            rsp_valid_in = have_byte;
         end else if (!pkt_ok) begin
            rsp_valid_in             = 1'b1;
            rsp_word_in.reply_byte   = have_byte ? ob : 8'h00;
            rsp_word_in.end_of_reply = 1'b1;
            rsp_word_in.reply_status = 1'b1;
         end else if (have_byte) begin
            rsp_valid_in   = 1'b1;
            tail_active_in = 1'b1;
            tail_idx_in    = '0;
         end else begin
            rsp_valid_in           = 1'b1;
            rsp_word_in.reply_byte = tail_byte('0, answer_address_ff);
            tail_active_in         = 1'b1;
            tail_idx_in            = TAIL_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_address_ff <= ANSWER_ADDRESS_RESET;
         in_valid_ff       <= 1'b0;
         pos_ff            <= '0;
         nlabel_ff         <= LABEL_START;
         found_ff          <= 1'b0;
         qend_ff           <= '0;
         tail_active_ff    <= 1'b0;
         tail_idx_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_ANSWER_ADDRESS)) begin
            answer_address_ff <= csr_pwdata;
         end
         if (in_take) begin
            in_valid_ff <= req_valid;
         end
         if (proc_go) begin
            if (in_eop_ff) begin
               pos_ff    <= '0;
               nlabel_ff <= LABEL_START;
               found_ff  <= 1'b0;
               qend_ff   <= '0;
            end else begin
               pos_ff    <= pos_in;
               nlabel_ff <= nlabel_in;
               found_ff  <= found_in;
               qend_ff   <= qend_in;
            end
         end
         tail_active_ff <= tail_active_in;
         tail_idx_ff    <= tail_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_byte_ff <= req_packet_byte;
         in_eop_ff  <= req_end_of_packet;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== sim/tb_captive_dns_reply_rewriter_top.sv =====
// ----------------------------------------------------------------------------
// tb_captive_dns_reply_rewriter_top
// Streams DNS queries into the reply rewriter and checks every reply word.
// ----------------------------------------------------------------------------
// A local model of the rewriter tracks the header rewrite, the question-name
// label walk and the answer record, and queues the expected reply words for
// each accepted query byte. Directed queries cover short packets, missing and
// late question ends and long labels; random queries are mostly well formed
// with some truncated or junk packets. Both sides idle at random, the
// receiver holds off now and then for a long stretch, and the answer address
// is rewritten between phases and after every second random packet.
module tb_captive_dns_reply_rewriter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cdrr_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int RANDOM_BYTES     = 80;
   localparam int LONG_HOLD_EVERY  = 150;
   localparam int LONG_HOLD_CYCLES = 300;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ANSWER_ADDRESS = CSR_ADDR_W'(4 * REG_ANSWER_ADDRESS);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED       = CSR_ADDR_W'(4);

   class dns_reply_scoreboard;
      logic [CSR_DATA_W-1:0] answer_address;
      logic [POS_W-1:0]      byte_pos;
      logic [POS_W-1:0]      next_label;
      logic [POS_W-1:0]      qend;
      bit                    qend_found;
      rsp_word_type          reply_words[$];
      int                    failures;

      function new();
         answer_address = ANSWER_ADDRESS_RESET;
         failures = 0;
         restart_packet();
      endfunction

      function void restart_packet();
         byte_pos = '0;
         next_label = LABEL_START;
         qend_found = 1'b0;
         qend = '0;
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("ERROR %0t: %s", $realtime, msg);
      endfunction

      function void write_register(int index, logic [CSR_DATA_W-1:0] value);
         if (index == REG_ANSWER_ADDRESS) answer_address = value;
      endfunction

      function void check_register(logic [CSR_DATA_W-1:0] value);
         if (value !== answer_address)
            note_failure($sformatf("answer_address read: expected %h, got %h",
                                   answer_address, value));
      endfunction

      function void queue_word(logic [7:0] b, logic last, logic status);
         rsp_word_type w;
         w.reply_byte = b;
         w.end_of_reply = last;
         w.reply_status = status;
         reply_words.push_back(w);
      endfunction

      function void take_query_byte(logic [7:0] b, logic eop);
         int         p;
         int         nx;
         int         len;
         bit         have;
         logic [7:0] ob;
         logic [7:0] answer_head [12];
         answer_head = '{8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
                         8'h00, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h04};
         have = 1'b0;
         ob = '0;
         if (byte_pos < MAX_PACKET_DEF) begin
            p = int'(byte_pos);
            if (!(qend_found && p >= int'(qend))) begin
               have = 1'b1;
               if (p == POS_FLAGS_HI) ob = FLAGS_HI_BYTE;
               else if (p == POS_FLAGS_LO) ob = FLAGS_LO_BYTE;
               else if (p == POS_ANCOUNT_LO) ob = ANCOUNT_BYTE;
               else if (p == POS_ANCOUNT_HI || (p >= POS_NSCOUNT_HI && p <= POS_ARCOUNT_LO))
                  ob = 8'h00;
               else ob = b;
            end
            if (!qend_found && p == int'(next_label)) begin
               if (b == 8'h00) begin
                  qend_found = 1'b1;
                  qend = POS_W'(p + int'(QEND_OFFSET));
               end else begin
                  nx = p + int'(b) + 1;
                  next_label = (nx > int'(LABEL_LIMIT)) ? POS_W'(LABEL_LIMIT) : POS_W'(nx);
               end
            end
            byte_pos = POS_W'(p + 1);
         end
         if (!eop) begin
            if (have) queue_word(ob, 1'b0, 1'b0);
            return;
         end
         len = int'(byte_pos);
         if (len >= int'(HEADER_LEN) && qend_found && int'(qend) <= len &&
             int'(qend) + int'(ANSWER_LEN) <= int'(MAX_PACKET_DEF)) begin
            if (have) queue_word(ob, 1'b0, 1'b0);
            foreach (answer_head[i]) queue_word(answer_head[i], 1'b0, 1'b0);
            queue_word(answer_address[31:24], 1'b0, 1'b0);
            queue_word(answer_address[23:16], 1'b0, 1'b0);
            queue_word(answer_address[15:8], 1'b0, 1'b0);
            queue_word(answer_address[7:0], 1'b1, 1'b0);
         end else begin
            queue_word(have ? ob : 8'h00, 1'b1, 1'b1);
         end
         restart_packet();
      endfunction

      function void check_reply_word(logic [7:0] b, logic eor, logic status);
         rsp_word_type want;
         if (reply_words.size() == 0) begin
            note_failure($sformatf("unexpected reply word %h end %b status %b", b, eor, status));
            return;
         end
         want = reply_words.pop_front();
         if (want.reply_byte !== b || want.end_of_reply !== eor ||
             want.reply_status !== status)
            note_failure($sformatf("reply word: expected %h end %b status %b, got %h end %b status %b",
                                   want.reply_byte, want.end_of_reply, want.reply_status,
                                   b, eor, status));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_packet_byte = 8'h00;
   logic                  req_end_of_packet = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_reply_byte;
   logic                  rsp_end_of_reply;
   logic                  rsp_reply_status;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dns_reply_scoreboard sb = new();
   logic [7:0]          pkt[$];
   bit                  sender_no_gaps = 1'b0;
   int                  idle_cycles = 0;

   captive_dns_reply_rewriter_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_packet_byte   (req_packet_byte),
      .req_end_of_packet (req_end_of_packet),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_end_of_reply  (rsp_end_of_reply),
      .rsp_reply_status  (rsp_reply_status),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_reply_word(rsp_reply_byte, rsp_end_of_reply, rsp_reply_status);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("captive_dns_reply_rewriter_top test failed");
         $finish;
      end
   end

   // receiver: random stalls, quiet stretches and a long hold-off now and then
   initial begin
      int hold;
      int accepted;
      accepted = 0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (accepted > 0 && accepted % LONG_HOLD_EVERY == 0) hold = LONG_HOLD_CYCLES;
         else if ((accepted / 40) % 3 == 0) hold = 0;
         else hold = $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         accepted++;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eop);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_packet_byte <= b;
      req_end_of_packet <= eop;
      do @(posedge clock); while (req_stall);
      sb.take_query_byte(b, eop);
   endtask

   task automatic send_packet();
      sender_no_gaps = ($urandom_range(0, 3) == 0);
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.reply_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_register(int'(addr) / 4, data);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_answer_register();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_ANSWER_ADDRESS;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.check_register(csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_answer_address(input logic [CSR_DATA_W-1:0] value);
      drain();
      csr_write(ADDR_ANSWER_ADDRESS, value);
      check_answer_register();
   endtask

   function automatic void start_header(int header_fill);
      pkt.delete();
      for (int i = 0; i < int'(HEADER_LEN); i++)
         pkt.push_back(header_fill < 0 ? 8'($urandom) : 8'(header_fill));
   endfunction

   function automatic void close_question(int extra);
      pkt.push_back(8'h00);
      for (int i = 0; i < 4 + extra; i++) pkt.push_back(8'($urandom));
   endfunction

   function automatic void build_query(int labels, int max_label, int extra, int header_fill);
      int n;
      start_header(header_fill);
      for (int l = 0; l < labels; l++) begin
         n = $urandom_range(1, max_label);
         pkt.push_back(8'(n));
         for (int i = 0; i < n; i++) pkt.push_back(8'($urandom));
      end
      close_question(extra);
   endfunction

   function automatic void build_junk(int len, int lo);
      pkt.delete();
      for (int i = 0; i < len; i++) pkt.push_back(8'($urandom_range(lo, 255)));
   endfunction

   function automatic void truncate_packet(int keep);
      while (pkt.size() > keep) void'(pkt.pop_back());
   endfunction

   initial begin
      int sent_bytes;
      int pkt_count;
      int kind;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_answer_register();

      build_query(1, 3, 0, 255);
      send_packet();
      build_query(2, 10, 3, 0);
      send_packet();
      build_junk(1, 255);
      send_packet();
      build_junk(11, 0);
      send_packet();
      start_header(-1);
      send_packet();
      build_query(2, 5, 0, -1);
      truncate_packet(pkt.size() - 2);
      send_packet();
      build_query(3, 63, 0, -1);
      send_packet();
      build_query(0, 1, 0, -1);
      send_packet();

      set_answer_address(32'h0000_0000);
      start_header(-1);
      pkt.push_back(8'hFF);
      for (int i = 0; i < 27; i++) pkt.push_back(8'($urandom));
      send_packet();

      drain();
      csr_write(ADDR_ANSWER_ADDRESS, 32'hFFFF_FFFF);
      csr_write(ADDR_UNMAPPED, $urandom);
      check_answer_register();

      set_answer_address($urandom);
      sent_bytes = 0;
      pkt_count = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            build_query($urandom_range(0, 4), 12,
                        ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0, -1);
         end else if (kind == 7) begin
            build_query($urandom_range(0, 3), 10, 0, -1);
            truncate_packet($urandom_range(1, pkt.size()));
         end else if (kind == 8) begin
            build_junk($urandom_range(1, 40), 0);
         end else begin
            build_junk($urandom_range(1, 11), 0);
         end
         send_packet();
         sent_bytes += pkt.size();
         pkt_count++;
         if (pkt_count % 2 == 0) begin
            case ($urandom_range(0, 3))
               0:       set_answer_address(32'h0000_0000);
               1:       set_answer_address(32'hFFFF_FFFF);
               default: set_answer_address($urandom);
            endcase
         end
      end

      drain();
      if (sb.failures == 0 && sb.reply_words.size() == 0)
         $display("captive_dns_reply_rewriter_top test passed");
      else
         $display("captive_dns_reply_rewriter_top test failed");
      $finish;
   end

endmodule
